>>> rtl/u8c_pkg.sv
package u8c_pkg;

	localparam int unsigned PointW = 21;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned KindW  = 2;

	localparam logic [KindW-1:0] KIND_POINT = 2'd0;
	localparam logic [KindW-1:0] KIND_BYTE  = 2'd1;
	localparam logic [KindW-1:0] KIND_ERROR = 2'd2;

	typedef logic [PointW-1:0] point_t;
	typedef logic [ByteW-1:0]  byte_t;
	typedef logic [1:0]        idx_t;

	typedef struct packed {
		logic                 has_result;
		logic [KindW-1:0]     kind;
		point_t               point;
	} u8c_dec_res_t;

endpackage

>>> rtl/u8c_dec.sv
module u8c_dec
	import u8c_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  byte_t        in_byte,
	output u8c_dec_res_t res
);

	point_t partial_q;
	idx_t   pending_q;
	point_t partial_d;
	idx_t   pending_d;
	idx_t   pending_m1;
	point_t merged;

	assign pending_m1 = pending_q - 2'd1;

	always_comb begin
		unique case (pending_m1)
			2'd0:    merged = partial_q | {15'd0, in_byte[5:0]};
			2'd1:    merged = partial_q | {9'd0, in_byte[5:0], 6'd0};
			2'd2:    merged = partial_q | {3'd0, in_byte[5:0], 12'd0};
			default: merged = partial_q | {in_byte[2:0], 18'd0};
		endcase
	end

	always_comb begin
		partial_d      = partial_q;
		pending_d      = pending_q;
		res.has_result = 1'b0;
		res.kind       = KIND_POINT;
		res.point      = '0;
		if (pending_q == 2'd0) begin
			priority if (in_byte[7] == 1'b0) begin
				res.has_result = 1'b1;
				res.point      = {13'd0, in_byte};
			end else if (in_byte[7:3] == 5'b11110) begin
				partial_d = {in_byte[2:0], 18'd0};
				pending_d = 2'd3;
			end else if (in_byte[7:4] == 4'b1110) begin
				partial_d = {5'd0, in_byte[3:0], 12'd0};
				pending_d = 2'd2;
			end else if (in_byte[7:5] == 3'b110) begin
				partial_d = {10'd0, in_byte[4:0], 6'd0};
				pending_d = 2'd1;
			end else begin
				partial_d      = '0;
				res.has_result = 1'b1;
				res.kind       = KIND_ERROR;
			end
		end else if (in_byte[7:6] != 2'b10) begin
			partial_d      = '0;
			pending_d      = 2'd0;
			res.has_result = 1'b1;
			res.kind       = KIND_ERROR;
		end else begin
			pending_d = pending_m1;
			if (pending_m1 == 2'd0) begin
				partial_d      = '0;
				res.has_result = 1'b1;
				res.point      = merged;
			end else begin
				partial_d = merged;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= 2'd0;
		end else if (step) begin
			partial_q <= partial_d;
			pending_q <= pending_d;
		end
	end

endmodule

>>> rtl/u8c_enc.sv
module u8c_enc
	import u8c_pkg::*;
(
	input  point_t code_point,
	input  idx_t   idx,
	output byte_t  out_byte,
	output idx_t   last_idx
);

	byte_t b [4];

	always_comb begin
		b[0] = '0;
		b[1] = '0;
		b[2] = '0;
		b[3] = '0;
		priority if (code_point[20:7] == 14'd0) begin
			b[0]     = {1'b0, code_point[6:0]};
			last_idx = 2'd0;
		end else if (code_point[20:11] == 10'd0) begin
			b[0]     = {3'b110, code_point[10:6]};
			b[1]     = {2'b10, code_point[5:0]};
			last_idx = 2'd1;
		end else if (code_point[20:16] == 5'd0) begin
			b[0]     = {4'b1110, code_point[15:12]};
			b[1]     = {2'b10, code_point[11:6]};
			b[2]     = {2'b10, code_point[5:0]};
			last_idx = 2'd2;
		end else begin
			b[0]     = {5'b11110, code_point[20:18]};
			b[1]     = {2'b10, code_point[17:12]};
			b[2]     = {2'b10, code_point[11:6]};
			b[3]     = {2'b10, code_point[5:0]};
			last_idx = 2'd3;
		end
	end

	assign out_byte = b[idx];

endmodule

>>> rtl/utf8_codec_top.sv
// UTF-8 decoder and encoder. Each transaction is held in one input register and
// its results leave through one output register, one result per cycle while
// out_ready is high. A decode byte yields at most one result (a code point on an
// ASCII byte or final continuation byte, an error on a bad lead or continuation
// byte, nothing otherwise), so bytes stream at one per clock unless out_ready
// holds back a result. An encode transaction stays in the input register until
// it has emitted 1 to 4 bytes, the count set by the code point's size; last marks
// its final byte. A pending decode sequence is kept across encode transactions.
module utf8_codec_top
	import u8c_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  byte_t            in_byte,
	input  point_t           code_point,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [KindW-1:0] out_kind,
	output point_t           decoded_point,
	output byte_t            out_byte,
	output logic             last
);

	logic         valid_s1;
	logic         req_type_s1;
	byte_t        in_byte_s1;
	point_t       code_point_s1;
	idx_t         enc_idx_q;
	logic         out_valid_q;

	u8c_dec_res_t dec_res;
	byte_t        enc_byte;
	idx_t         enc_last_idx;
	logic         has_result;
	logic         out_free;
	logic         s1_fire;
	logic         s1_done;
	logic         enc_last;

	u8c_dec u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_fire && !req_type_s1),
		.in_byte (in_byte_s1),
		.res     (dec_res)
	);

	u8c_enc u_enc (
		.code_point (code_point_s1),
		.idx        (enc_idx_q),
		.out_byte   (enc_byte),
		.last_idx   (enc_last_idx)
	);

	assign enc_last   = (enc_idx_q == enc_last_idx);
	assign has_result = req_type_s1 ? 1'b1 : dec_res.has_result;
	assign out_free   = !out_valid_q || out_ready;
	assign s1_fire    = valid_s1 && (!has_result || out_free);
	assign s1_done    = s1_fire && (!req_type_s1 || enc_last);
	assign in_ready   = !valid_s1 || s1_done;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			enc_idx_q <= 2'd0;
		end else begin
			if (in_ready) begin
				valid_s1  <= in_valid;
				enc_idx_q <= 2'd0;
			end else if (s1_fire && req_type_s1) begin
				enc_idx_q <= enc_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_type_s1   <= req_type;
			in_byte_s1    <= in_byte;
			code_point_s1 <= code_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_result) begin
			if (req_type_s1) begin
				out_kind      <= KIND_BYTE;
				decoded_point <= '0;
				out_byte      <= enc_byte;
				last          <= enc_last;
			end else begin
				out_kind      <= dec_res.kind;
				decoded_point <= dec_res.point;
				out_byte      <= '0;
				last          <= 1'b1;
			end
		end
	end

endmodule

>>> tb/sv/tb_top.sv
module tb_top
	import u8c_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic REQ_DECODE = 1'b0;
	localparam logic REQ_ENCODE = 1'b1;
	localparam int unsigned RX_HOLD_CYCLES = 300;
	localparam int unsigned MAX_REPORTS = 40;

	typedef struct packed {
		logic   req;
		byte_t  data;
		point_t cp;
	} codec_req_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		point_t           point;
		byte_t            data;
		logic             fin;
	} codec_result_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} utf8_seq_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             req_type = REQ_DECODE;
	byte_t            in_byte = '0;
	point_t           code_point = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [KindW-1:0] out_kind;
	point_t           decoded_point;
	byte_t            out_byte;
	logic             last;

	codec_req_t    pending_reqs[$];
	codec_result_t expected_results[$];
	codec_req_t    next_req;

	point_t        dec_acc = '0;
	logic [1:0]    dec_due = '0;

	logic          in_taken = 1'b0;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	int unsigned   rx_hold_reqs = 0;
	int unsigned   rx_hold_seen = 0;
	int unsigned   rx_hold_left = 0;

	int unsigned   err_cnt = 0;
	int unsigned   n_decode = 0;
	int unsigned   n_encode = 0;
	int unsigned   n_points = 0;
	int unsigned   n_bytes = 0;
	int unsigned   n_errors = 0;

	utf8_codec_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.in_byte      (in_byte),
		.code_point   (code_point),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.decoded_point(decoded_point),
		.out_byte     (out_byte),
		.last         (last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what);
		if (err_cnt < MAX_REPORTS) begin
			$display("mismatch at %0t ns: %s", $time, what);
		end
		err_cnt++;
	endtask

	function automatic utf8_seq_t utf8_encode(point_t cp);
		utf8_seq_t s;
		s.bytes = '0;
		if (cp < 21'h80) begin
			s.len = 3'd1;
			s.bytes[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			s.len = 3'd2;
			s.bytes[0] = {3'b110, cp[10:6]};
			s.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			s.len = 3'd3;
			s.bytes[0] = {4'b1110, cp[15:12]};
			s.bytes[1] = {2'b10, cp[11:6]};
			s.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			s.len = 3'd4;
			s.bytes[0] = {5'b11110, cp[20:18]};
			s.bytes[1] = {2'b10, cp[17:12]};
			s.bytes[2] = {2'b10, cp[11:6]};
			s.bytes[3] = {2'b10, cp[5:0]};
		end
		return s;
	endfunction

	function automatic void push_result(logic [KindW-1:0] kind, point_t point, byte_t data,
			logic fin);
		codec_result_t r;
		r.kind  = kind;
		r.point = point;
		r.data  = data;
		r.fin   = fin;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_codec(codec_req_t r);
		utf8_seq_t s;
		byte_t     b;
		if (r.req == REQ_ENCODE) begin
			s = utf8_encode(r.cp);
			for (int i = 0; i < s.len; i++) begin
				push_result(KIND_BYTE, '0, s.bytes[i], (i == s.len - 1));
			end
		end else begin
			b = r.data;
			if (dec_due == 2'd0) begin
				if (b[7] == 1'b0) begin
					push_result(KIND_POINT, point_t'(b), '0, 1'b1);
				end else if (b[7:3] == 5'b11110) begin
					dec_acc = {b[2:0], 18'b0};
					dec_due = 2'd3;
				end else if (b[7:4] == 4'b1110) begin
					dec_acc = {5'b0, b[3:0], 12'b0};
					dec_due = 2'd2;
				end else if (b[7:5] == 3'b110) begin
					dec_acc = {10'b0, b[4:0], 6'b0};
					dec_due = 2'd1;
				end else begin
					dec_acc = '0;
					push_result(KIND_ERROR, '0, '0, 1'b1);
				end
			end else if (b[7:6] != 2'b10) begin
				dec_acc = '0;
				dec_due = 2'd0;
				push_result(KIND_ERROR, '0, '0, 1'b1);
			end else begin
				dec_due = dec_due - 2'd1;
				dec_acc = dec_acc | (point_t'(b[5:0]) << (6 * dec_due));
				if (dec_due == 2'd0) begin
					push_result(KIND_POINT, dec_acc, '0, 1'b1);
					dec_acc = '0;
				end
			end
		end
	endfunction

	function automatic point_t rand_point();
		case ($urandom_range(3))
			0: return point_t'($urandom_range(32'h7f));
			1: return point_t'($urandom_range(32'h7ff, 32'h80));
			2: return point_t'($urandom_range(32'hffff, 32'h800));
			default: return point_t'($urandom_range(32'h1fffff, 32'h10000));
		endcase
	endfunction

	function automatic void queue_item(logic req, byte_t data, point_t cp);
		codec_req_t r;
		r.req  = req;
		r.data = data;
		r.cp   = cp;
		pending_reqs.push_back(r);
	endfunction

	task automatic queue_random_items(int unsigned count);
		int unsigned added;
		int unsigned mode;
		int unsigned cut;
		utf8_seq_t   s;
		byte_t       bad;
		added = 0;
		while (added < count) begin
			mode = $urandom_range(99);
			if (mode < 40) begin
				s = utf8_encode(rand_point());
				for (int i = 0; i < s.len; i++) begin
					queue_item(REQ_DECODE, s.bytes[i], point_t'($urandom));
					added++;
					if (i + 1 < s.len && $urandom_range(9) == 0) begin
						queue_item(REQ_ENCODE, byte_t'($urandom), rand_point());
						added++;
					end
				end
			end else if (mode < 75) begin
				queue_item(REQ_ENCODE, byte_t'($urandom), rand_point());
				added++;
			end else if (mode < 88) begin
				queue_item(REQ_DECODE, byte_t'($urandom), point_t'($urandom));
				added++;
			end else begin
				do s = utf8_encode(rand_point()); while (s.len < 2);
				cut = $urandom_range(s.len - 1, 1);
				for (int i = 0; i < cut; i++) begin
					queue_item(REQ_DECODE, s.bytes[i], point_t'($urandom));
					added++;
				end
				bad = byte_t'($urandom);
				if (bad[7:6] == 2'b10) bad[6] = 1'b1;
				queue_item(REQ_DECODE, bad, point_t'($urandom));
				added++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending_reqs.pop_front();
				in_valid   <= 1'b1;
				req_type   <= next_req.req;
				in_byte    <= next_req.data;
				code_point <= next_req.cp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold_seen != rx_hold_reqs) begin
			rx_hold_seen <= rx_hold_reqs;
			rx_hold_left <= RX_HOLD_CYCLES;
			out_ready    <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_ready    <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		codec_result_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			next_req.req  = req_type;
			next_req.data = in_byte;
			next_req.cp   = code_point;
			predict_codec(next_req);
			if (req_type == REQ_ENCODE) n_encode++;
			else n_decode++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (out_kind == KIND_POINT) n_points++;
			else if (out_kind == KIND_BYTE) n_bytes++;
			else n_errors++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d point %06h byte %02h",
					out_kind, decoded_point, out_byte));
			end else begin
				want = expected_results.pop_front();
				if (out_kind !== want.kind)
					report_mismatch($sformatf("out_kind %0d, want %0d", out_kind, want.kind));
				if (decoded_point !== want.point)
					report_mismatch($sformatf("decoded_point %06h, want %06h",
						decoded_point, want.point));
				if (out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
				if (last !== want.fin)
					report_mismatch($sformatf("last %0b, want %0b", last, want.fin));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_item(REQ_DECODE, 8'h00, 21'h1fffff);
		queue_item(REQ_DECODE, 8'h7f, 21'h0);
		queue_item(REQ_DECODE, 8'h80, 21'h0);
		queue_item(REQ_DECODE, 8'hff, 21'h0);
		queue_item(REQ_DECODE, 8'hc3, 21'h0);
		queue_item(REQ_ENCODE, 8'hff, 21'h1fffff);
		queue_item(REQ_DECODE, 8'hbf, 21'h0);
		queue_item(REQ_DECODE, 8'he0, 21'h0);
		queue_item(REQ_DECODE, 8'hc2, 21'h0);
		queue_item(REQ_DECODE, 8'hf7, 21'h0);
		queue_item(REQ_DECODE, 8'hbf, 21'h0);
		queue_item(REQ_DECODE, 8'hbf, 21'h0);
		queue_item(REQ_DECODE, 8'hbf, 21'h0);
		queue_item(REQ_ENCODE, 8'h00, 21'h0);
		queue_item(REQ_ENCODE, 8'h00, 21'h7f);
		queue_item(REQ_ENCODE, 8'h00, 21'h80);
		queue_item(REQ_ENCODE, 8'h00, 21'h7ff);
		queue_item(REQ_ENCODE, 8'h00, 21'h800);
		queue_item(REQ_ENCODE, 8'h00, 21'hffff);
		queue_item(REQ_ENCODE, 8'h00, 21'h10000);
		queue_item(REQ_DECODE, 8'hf8, 21'h0);
		queue_item(REQ_DECODE, 8'he1, 21'h0);
		queue_item(REQ_DECODE, 8'h80, 21'h0);
		queue_item(REQ_DECODE, 8'h80, 21'h0);
		wait_drained();

		queue_random_items(60);
		wait_drained();

		// stall the output while the input keeps offering transactions
		rx_hold_reqs++;
		queue_random_items(40);
		wait_drained();

		send_idle_pct = 88;
		queue_random_items(55);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 88;
		queue_random_items(55);
		wait_drained();

		send_idle_pct  = 20;
		recv_stall_pct = 20;
		queue_random_items(70);
		wait_drained();

		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("covered %0d decode and %0d encode transactions under five handshake phases",
			n_decode, n_encode);
		$display("checked %0d code points, %0d encoded bytes, %0d decode errors",
			n_points, n_bytes, n_errors);
		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
